### rtl/clcd_pkg.sv
// Shared types, constants and the power-on pin-state table of the character
// LCD sequencer. No dependencies.
`timescale 1ns / 1ps

package clcd_pkg;

  localparam int unsigned STEP_W = 5;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_SETCUR = 2'd2,
    OP_PUTCH = 2'd3
  } clcd_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } clcd_state_e;

  // Configuration register indexes.
  localparam logic CFG_COLUMN_COUNT = 1'b0;
  localparam logic CFG_ROW_COUNT    = 1'b1;

  localparam logic [5:0] COLUMN_COUNT_RESET = 6'd16;
  localparam logic [1:0] ROW_COUNT_RESET    = 2'd2;
  localparam logic [5:0] COLUMN_MAX         = 6'd40;

  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;

  localparam logic [15:0] HOLD_E_HIGH   = 16'd1;
  localparam logic [15:0] HOLD_E_LOW    = 16'd50;
  localparam logic [15:0] HOLD_POWER_ON = 16'd50000;
  localparam logic [15:0] HOLD_CLEAR    = 16'd2050;
  localparam logic [15:0] HOLD_WAKE1    = 16'd5050;
  localparam logic [15:0] HOLD_WAKE     = 16'd200;

  localparam logic [STEP_W-1:0] INIT_LAST_STEP = 5'd28;
  localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 5'd3;

  typedef struct packed {
    logic        reg_select;
    logic        enable;
    logic [3:0]  data_lines;
    logic [15:0] hold_us;
  } clcd_pins_t;

  // Controller to datapath.
  typedef struct packed {
    logic              load;
    logic              emit;
    logic [STEP_W-1:0] step;
  } clcd_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
    logic last_step;
  } clcd_stat_t;

  // Pin state of step k of the power-on run: wait, four wake-up nibbles,
  // then the function set, display off, clear, entry mode and display on
  // bytes as two nibbles each.
  function automatic clcd_pins_t init_step(input logic [STEP_W-1:0] k);
    clcd_pins_t p;
    p.reg_select = 1'b0;
    p.enable     = k[0];
    case (k) inside
      5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6: p.data_lines = 4'h3;
      5'd7, 5'd8, 5'd9, 5'd10:            p.data_lines = 4'h2;
      5'd11, 5'd12, 5'd15, 5'd16:         p.data_lines = 4'h8;
      5'd19, 5'd20:                       p.data_lines = 4'h1;
      5'd23, 5'd24:                       p.data_lines = 4'h6;
      5'd27, 5'd28:                       p.data_lines = 4'hC;
      default:                            p.data_lines = 4'h0;
    endcase
    case (k) inside
      5'd0:                p.hold_us = HOLD_POWER_ON;
      5'd2:                p.hold_us = HOLD_WAKE1;
      5'd4, 5'd6, 5'd8:    p.hold_us = HOLD_WAKE;
      5'd20:               p.hold_us = HOLD_CLEAR;
      default:             p.hold_us = k[0] ? HOLD_E_HIGH : HOLD_E_LOW;
    endcase
    return p;
  endfunction

endpackage

### rtl/clcd_req_if.sv
// Command request channel of the LCD sequencer.
// Depends on nothing.
`timescale 1ns / 1ps

interface clcd_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] char_code;
  logic [7:0] column;
  logic [7:0] row;

  modport source (output valid, op, char_code, column, row, input ready);
  modport sink (input valid, op, char_code, column, row, output ready);
endinterface

### rtl/clcd_res_if.sv
// Pin-state result channel of the LCD sequencer.
// Depends on nothing.
`timescale 1ns / 1ps

interface clcd_res_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic        enable;
  logic [3:0]  data_lines;
  logic [15:0] hold_us;
  logic        last;

  modport source (output valid, reg_select, enable, data_lines, hold_us, last,
                  input ready);
  modport sink (input valid, reg_select, enable, data_lines, hold_us, last,
                output ready);
endinterface

### rtl/clcd_ctrl.sv
// Step sequencer state machine of the LCD sequencer.
// Depends on clcd_pkg.
`timescale 1ns / 1ps

module clcd_ctrl
  import clcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  clcd_stat_t stat_i,
  output clcd_cmd_t  cmd_o
);

  clcd_state_e       state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (stat_i.out_free && stat_i.last_step) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.emit  = 1'b0;
    cmd_o.step  = step_q;
    step_d      = step_q;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
        step_d      = '0;
      end
      ST_RUN: begin
        cmd_o.emit = stat_i.out_free;
        if (stat_i.out_free) begin
          step_d = stat_i.last_step ? '0 : step_q + 1'b1;
        end
      end
      default: step_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  a_idle_step_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (step_q == '0))
    else $error("step counter not cleared while idle");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= INIT_LAST_STEP)
    else $error("step counter ran past the longest run");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && stat_i.last_step) |=> (state_q == ST_IDLE))
    else $error("run did not end after its last step");

  a_load_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_RUN && step_q == '0))
    else $error("accepted request did not start a run");

endmodule

### rtl/clcd_datapath.sv
// Datapath of the LCD sequencer: configuration, command latch with cursor
// clamping, pin-state generation and the output register. Depends on clcd_pkg.
`timescale 1ns / 1ps

module clcd_datapath
  import clcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  input  logic [1:0]  op_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  column_i,
  input  logic [7:0]  row_i,
  input  clcd_cmd_t   cmd_i,
  output clcd_stat_t  stat_o,
  input  logic        res_ready_i,
  output logic        res_valid_o,
  output clcd_pins_t  res_pins_o,
  output logic        res_last_o
);

  logic [5:0] column_count_q;
  logic [1:0] row_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= COLUMN_COUNT_RESET;
      row_count_q    <= ROW_COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_COLUMN_COUNT: column_count_q <= cfg_data_i;
        CFG_ROW_COUNT:    row_count_q    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Cursor clamping against the effective display size.
  logic [5:0] cols_eff;
  logic [5:0] col_clamped;
  logic       row_sel;

  always_comb begin
    if (column_count_q == '0)            cols_eff = 6'd1;
    else if (column_count_q > COLUMN_MAX) cols_eff = COLUMN_MAX;
    else                                  cols_eff = column_count_q;
    col_clamped = (column_i >= {2'b00, cols_eff}) ? cols_eff - 6'd1 : column_i[5:0];
    row_sel     = row_count_q[1] && (row_i != '0);
  end

  logic       is_init_q, rs_q, extra_q;
  logic       is_init_d, rs_d, extra_d;
  logic [7:0] byte_q, byte_d;

  always_comb begin
    is_init_d = 1'b0;
    rs_d      = 1'b0;
    extra_d   = 1'b0;
    byte_d    = char_code_i;
    case (clcd_op_e'(op_i))
      OP_INIT: is_init_d = 1'b1;
      OP_CLEAR: begin
        extra_d = 1'b1;
        byte_d  = CMD_CLEAR;
      end
      OP_SETCUR: byte_d = CMD_SET_DDRAM | {1'b0, row_sel, col_clamped};
      default: rs_d = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      is_init_q <= is_init_d;
      rs_q      <= rs_d;
      extra_q   <= extra_d;
      byte_q    <= byte_d;
    end
  end

  // A byte run is high nibble strobe, high nibble settle, low nibble strobe,
  // low nibble settle.
  clcd_pins_t step_pins;

  always_comb begin
    if (is_init_q) begin
      step_pins = init_step(cmd_i.step);
    end else begin
      step_pins.reg_select = rs_q;
      step_pins.enable     = ~cmd_i.step[0];
      step_pins.data_lines = cmd_i.step[1] ? byte_q[3:0] : byte_q[7:4];
      if (!cmd_i.step[0])                  step_pins.hold_us = HOLD_E_HIGH;
      else if (cmd_i.step[1] && extra_q)   step_pins.hold_us = HOLD_CLEAR;
      else                                 step_pins.hold_us = HOLD_E_LOW;
    end
    stat_o.last_step = (cmd_i.step == (is_init_q ? INIT_LAST_STEP : BYTE_LAST_STEP));
    stat_o.out_free  = !res_valid_o || res_ready_i;
  end

  logic valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      valid_q <= 1'b1;
    end else if (res_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_pins_o <= step_pins;
      res_last_o <= stat_o.last_step;
    end
  end

  assign res_valid_o = valid_q;

endmodule

### rtl/char_lcd_4bit_sequencer_unit.sv
// Top level of the character LCD 4-bit bus sequencer.
// Depends on clcd_pkg, clcd_req_if, clcd_res_if, clcd_ctrl and clcd_datapath.
//
// Usage: each request on req_i is one command (init, clear, set cursor or
// put character). The block answers with a run of pin states on res_o, each
// giving RS, E, D7..D4 and the microseconds the host must hold it; the final
// state of a run carries last. A character, clear or set cursor request makes
// four results, init makes twenty-nine.
// Timing: a request is taken in the cycle after the previous run's last
// result entered the output register. The controller's step counter then
// loads one pin state per cycle into that register when the receiver keeps
// up. After a request is accepted, the run state is entered and the first
// result is then registered into the output register once that is free.
// When the receiver stalls, the output register holds its result and the
// step counter waits; no result is dropped.
// Reset clears the state machine and the output valid, and sets the display
// size to 16 columns and 2 rows. The configuration port writes column_count
// (index 0) or row_count (index 1), one per write; write it only while idle.
`timescale 1ns / 1ps

module char_lcd_4bit_sequencer_unit
  import clcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  clcd_req_if.sink    req_i,
  clcd_res_if.source  res_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [5:0]  cfg_data_i
);

  clcd_cmd_t  cmd;
  clcd_stat_t stat;
  clcd_pins_t pins;

  // The controller only sequences steps; all payload lives in the datapath.
  clcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  clcd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .op_i        (req_i.op),
    .char_code_i (req_i.char_code),
    .column_i    (req_i.column),
    .row_i       (req_i.row),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .res_pins_o  (pins),
    .res_last_o  (res_o.last)
  );

  assign res_o.reg_select = pins.reg_select;
  assign res_o.enable     = pins.enable;
  assign res_o.data_lines = pins.data_lines;
  assign res_o.hold_us    = pins.hold_us;

endmodule
